// File: design/slbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED and beeper sequencer package
// Shared widths, register indexes, action codes and reset values.
// ----------------------------------------------------------------------------
package slbs_pkg;

	localparam int TimeW = 32;
	localparam int CfgW  = 24;
	localparam int IdxW  = 3;
	localparam int TogW  = 3;

	typedef logic [TimeW-1:0] time_t;
	typedef logic [CfgW-1:0]  cfg_val_t;
	typedef logic [TogW-1:0]  tog_cnt_t;

	typedef enum logic [1:0] {
		ACT_UPDATE  = 2'd0,
		ACT_SUCCESS = 2'd1,
		ACT_FAILURE = 2'd2
	} action_t;

	typedef enum logic [IdxW-1:0] {
		REG_HEART_PERIOD = 3'd0,
		REG_HEART_ON     = 3'd1,
		REG_ARM_PERIOD   = 3'd2,
		REG_ARM_ON       = 3'd3,
		REG_SHORT_BEEP   = 3'd4,
		REG_LONG_BEEP    = 3'd5
	} reg_idx_t;

	localparam cfg_val_t HeartPeriodRst = 24'd1000000;
	localparam cfg_val_t HeartOnRst     = 24'd250000;
	localparam cfg_val_t ArmPeriodRst   = 24'd500000;
	localparam cfg_val_t ArmOnRst       = 24'd250000;
	localparam cfg_val_t ShortBeepRst   = 24'd100000;
	localparam cfg_val_t LongBeepRst    = 24'd1000000;

	// Toggle counts: two per beep.
	localparam tog_cnt_t TogSuccess  = 3'd4;
	localparam tog_cnt_t TogFailure  = 3'd2;
	localparam tog_cnt_t TogFailsafe = 3'd2;

	// Request from the top level to the beeper for one item.
	typedef struct packed {
		logic step;
		logic start_success;
		logic start_failure;
		logic update;
		logic failsafe;
	} beep_req_t;

endpackage

// File: design/slbs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one timestamp update or beep request.
// ----------------------------------------------------------------------------
interface slbs_in_if import slbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [TimeW-1:0]  time_us;
	logic              armed;
	logic              safety_engaged;
	logic              failsafe;

	modport source (output valid, output action, output time_us, output armed,
		output safety_engaged, output failsafe, input ready);
	modport sink (input valid, input action, input time_us, input armed,
		input safety_engaged, input failsafe, output ready);
endinterface

// File: design/slbs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel carrying the LED and buzzer levels.
// ----------------------------------------------------------------------------
interface slbs_out_if;
	logic valid;
	logic ready;
	logic heart_led;
	logic arm_led;
	logic buzzer_on;

	modport source (output valid, output heart_led, output arm_led, output buzzer_on,
		input ready);
	modport sink (input valid, input heart_led, input arm_led, input buzzer_on,
		output ready);
endinterface

// File: design/slbs_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface slbs_cfg_if import slbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IdxW-1:0]  index;
	logic [CfgW-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/slbs_pulse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pulse timer
// Keeps a window start and gives the lit level for the current timestamp.
// ----------------------------------------------------------------------------
module slbs_pulse import slbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     upd,
	input  time_t    now,
	input  cfg_val_t period,
	input  cfg_val_t on_len,
	output logic     lit
);

	time_t start_q;
	time_t elapsed;
	logic  restart;

	assign elapsed = now - start_q;
	assign restart = elapsed > {{(TimeW-CfgW){1'b0}}, period};

	// After a restart the elapsed time is zero, so the LED is lit for any non-zero on-length.
	assign lit = restart ? (on_len != '0)
		: (elapsed < {{(TimeW-CfgW){1'b0}}, on_len});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (upd && restart) begin
			start_q <= now;
		end
	end

endmodule

// File: design/slbs_beeper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer sequencer
// Starts beep sequences and toggles the buzzer when each interval elapses.
// ----------------------------------------------------------------------------
module slbs_beeper import slbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  beep_req_t req,
	input  time_t     now,
	input  cfg_val_t  short_beep,
	input  cfg_val_t  long_beep,
	output logic      level
);

	time_t    toggle_time_q;
	tog_cnt_t toggles_q;
	cfg_val_t interval_q;
	logic     level_q;

	time_t    toggle_time_d;
	tog_cnt_t toggles_d;
	cfg_val_t interval_d;
	logic     level_d;

	time_t    base_time;
	tog_cnt_t base_toggles;
	cfg_val_t base_interval;
	logic     base_level;
	time_t    elapsed;

	always_comb begin
		base_time     = toggle_time_q;
		base_toggles  = toggles_q;
		base_interval = interval_q;
		base_level    = level_q;
		// A failsafe only starts a beep when no sequence is running.
		if (req.update && req.failsafe && (toggles_q == '0)) begin
			base_time     = '0;
			base_toggles  = TogFailsafe;
			base_interval = short_beep;
			base_level    = 1'b0;
		end
		elapsed = now - base_time;

		toggle_time_d = base_time;
		toggles_d     = base_toggles;
		interval_d    = base_interval;
		level_d       = base_level;
		if (req.start_success) begin
			toggle_time_d = '0;
			toggles_d     = TogSuccess;
			interval_d    = short_beep;
			level_d       = 1'b0;
		end else if (req.start_failure) begin
			toggle_time_d = '0;
			toggles_d     = TogFailure;
			interval_d    = long_beep;
			level_d       = 1'b0;
		end else if (req.update && (base_toggles != '0)
			&& (elapsed > {{(TimeW-CfgW){1'b0}}, base_interval})) begin
			level_d       = ~base_level;
			toggle_time_d = now;
			toggles_d     = base_toggles - tog_cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_time_q <= '0;
			toggles_q     <= '0;
			interval_q    <= '0;
			level_q       <= 1'b0;
		end else if (req.step) begin
			toggle_time_q <= toggle_time_d;
			toggles_q     <= toggles_d;
			interval_q    <= interval_d;
			level_q       <= level_d;
		end
	end

	assign level = level_q;

endmodule

// File: design/status_led_and_beeper_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED and beeper sequencer
// Drives a heartbeat LED, an arm LED and a buzzer from a microsecond timestamp.
// ----------------------------------------------------------------------------
// Usage: each item on item_in carries an action (update, success beeps or
// failure beep), the current timestamp and the armed, safety and failsafe
// flags. Every item gives exactly one result item on result_out with the
// heartbeat LED, arm LED and buzzer levels after that item.
// An accepted item waits in the input register until the result register is
// free, is then worked out against the timer state into the result register.
// One item per cycle is sustained while the receiver is ready; the state
// update for an item is a pair of 32-bit subtract-and-compare paths per timer.
// The result register is the LED and buzzer state itself, so while the
// receiver stalls it holds, one further item waits in the input register
// and item_in drops ready after that.
// The cfg channel is always ready and writes the six timing registers by
// index; writes to other indexes are ignored. Write only while idle.
// Reset (arst_n low) restores the default timings, clears all timers and
// levels and empties both registers.
// ----------------------------------------------------------------------------
module status_led_and_beeper_sequencer_top import slbs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	slbs_in_if.sink    item_in,
	slbs_out_if.source result_out,
	slbs_cfg_if.sink   cfg
);

	cfg_val_t heart_period_q, heart_on_q, arm_period_q, arm_on_q;
	cfg_val_t short_beep_q, long_beep_q;

	logic       valid_s1;
	logic [1:0] action_s1;
	time_t      time_s1;
	logic       armed_s1;
	logic       engaged_s1;
	logic       failsafe_s1;

	logic      out_valid_q;
	logic      heart_lit_q;
	logic      arm_lit_q;
	logic      advance;
	logic      accept;
	logic      is_update;
	logic      heart_nxt;
	logic      arm_pulse_nxt;
	logic      buzzer_level;
	beep_req_t beep_req;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heart_period_q <= HeartPeriodRst;
			heart_on_q     <= HeartOnRst;
			arm_period_q   <= ArmPeriodRst;
			arm_on_q       <= ArmOnRst;
			short_beep_q   <= ShortBeepRst;
			long_beep_q    <= LongBeepRst;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HEART_PERIOD: heart_period_q <= cfg.data;
				REG_HEART_ON:     heart_on_q     <= cfg.data;
				REG_ARM_PERIOD:   arm_period_q   <= cfg.data;
				REG_ARM_ON:       arm_on_q       <= cfg.data;
				REG_SHORT_BEEP:   short_beep_q   <= cfg.data;
				REG_LONG_BEEP:    long_beep_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Handshake: the input register moves on whenever the result register is free.
	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;
	assign accept        = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= item_in.action;
			time_s1     <= item_in.time_us;
			armed_s1    <= item_in.armed;
			engaged_s1  <= item_in.safety_engaged;
			failsafe_s1 <= item_in.failsafe;
		end
	end

	assign is_update = (action_s1 == ACT_UPDATE);

	slbs_pulse u_heart (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance && is_update),
		.now    (time_s1),
		.period (heart_period_q),
		.on_len (heart_on_q),
		.lit    (heart_nxt)
	);

	// The arm blink window only runs while disarmed with the switch released.
	slbs_pulse u_arm (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance && is_update && !armed_s1 && !engaged_s1),
		.now    (time_s1),
		.period (arm_period_q),
		.on_len (arm_on_q),
		.lit    (arm_pulse_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heart_lit_q <= 1'b0;
			arm_lit_q   <= 1'b0;
		end else if (advance && is_update) begin
			heart_lit_q <= heart_nxt;
			arm_lit_q   <= armed_s1 || (!engaged_s1 && arm_pulse_nxt);
		end
	end

	assign beep_req.step          = advance;
	assign beep_req.start_success = (action_s1 == ACT_SUCCESS);
	assign beep_req.start_failure = (action_s1 == ACT_FAILURE);
	assign beep_req.update        = is_update;
	assign beep_req.failsafe      = failsafe_s1;

	slbs_beeper u_beeper (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (beep_req),
		.now        (time_s1),
		.short_beep (short_beep_q),
		.long_beep  (long_beep_q),
		.level      (buzzer_level)
	);

	assign result_out.valid     = out_valid_q;
	assign result_out.heart_led = heart_lit_q;
	assign result_out.arm_led   = arm_lit_q;
	assign result_out.buzzer_on = buzzer_level;

endmodule

// File: design/slbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED and beeper sequencer checker
// Port-level assertions on the item and result channels.
// ----------------------------------------------------------------------------
module slbs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic heart_led,
	input logic arm_led,
	input logic buzzer_on
);

	// A stalled result item keeps its levels.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({heart_led, arm_led, buzzer_on}))
		else $error("result item changed while stalled");

	// With no result waiting the block always takes an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("item refused while result register empty");

	// An item taken while the output is free passes the input register and then shows its result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> ##1 out_valid)
		else $error("result item missing after accepted item");

	// Nothing comes out of an empty pipeline straight after reset.
	assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid during reset");

endmodule

bind status_led_and_beeper_sequencer_top slbs_checker u_slbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item_in.valid),
	.in_ready  (item_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.heart_led (result_out.heart_led),
	.arm_led   (result_out.arm_led),
	.buzzer_on (result_out.buzzer_on)
);
